FILE: rtl/core/lplcm_pkg.sv
// lplcm_pkg: shared constants for the literal pattern line/column matcher
// register index codes, payload widths and special byte values
// no dependencies
`default_nettype none

package lplcm_pkg;

    localparam int PATTERN_MAX_DEFAULT = 32;
    localparam int COUNT_BITS_DEFAULT  = 24;

    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 24;
    localparam int LEN_W       = 6;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 4;
    localparam int PAT_BYTES   = 32;
    localparam int PAT_IDX_W   = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [OUT_W-1:0]  count_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/lplcm_stream_if.sv
// lplcm_text_if and lplcm_match_if: valid/ready channels of the matcher
// text bytes in, line/column results out
// depends on lplcm_pkg
`default_nettype none

interface lplcm_text_if;
    import lplcm_pkg::*;

    logic  valid;
    logic  ready;
    byte_t text_byte;
    logic  file_start;

    modport source (output valid, output text_byte, output file_start, input ready);
    modport sink   (input valid, input text_byte, input file_start, output ready);
endinterface

interface lplcm_match_if;
    import lplcm_pkg::*;

    logic       valid;
    logic       ready;
    count_out_t line_number;
    count_out_t column_number;

    modport source (output valid, output line_number, output column_number, input ready);
    modport sink   (input valid, input line_number, input column_number, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/literal_pattern_line_column_matcher.sv
// literal_pattern_line_column_matcher: streaming literal search with line/column report
// depends on lplcm_pkg, lplcm_text_if, lplcm_match_if
`default_nettype none

// Takes one text byte per transaction and reports the 1-based line and start
// column of every occurrence of the configured pattern (1 to 32 bytes, set
// through the write port; the user must write it only while no transaction is
// in flight, as the block does not enforce this). The block sustains one byte
// per clock while no result waits on a stalled sink: a byte is compared against
// the line history while it sits in the input register and, on a match, lands in
// the result register when it leaves the input register. While a result waits
// on a stalled sink, the byte in the input register waits with it, whether or
// not it gives a result, and the input takes at most one byte behind the
// waiting result. No clearing pass is needed after reset.
module literal_pattern_line_column_matcher
#(
    parameter int PATTERN_MAX = lplcm_pkg::PATTERN_MAX_DEFAULT,
    parameter int COUNT_BITS  = lplcm_pkg::COUNT_BITS_DEFAULT
)(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    lplcm_text_if.sink                             text_in,
    lplcm_match_if.source                          match_out,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lplcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lplcm_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import lplcm_pkg::*;

    localparam int BOL_W  = $clog2(PATTERN_MAX + 1);
    localparam int WIDE_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [LEN_W-1:0]  pattern_length_reg;
    logic [WORD_W-1:0] pattern_word_reg [NUM_WORDS];
    byte_t             pat_bytes [PAT_BYTES];

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;
    logic  in_start_reg;

    // line state
    byte_t                 hist_reg [PATTERN_MAX];
    logic [BOL_W-1:0]      bol_reg;
    logic [COUNT_BITS-1:0] line_reg;
    logic [COUNT_BITS-1:0] col_reg;
    logic                  binary_reg;

    byte_t                 hist_cur [PATTERN_MAX];
    logic [BOL_W-1:0]      bol_cur;
    logic [COUNT_BITS-1:0] line_cur;
    logic [COUNT_BITS-1:0] col_cur;
    logic                  binary_cur;

    byte_t                 hist_next [PATTERN_MAX];
    logic [BOL_W-1:0]      bol_next;
    logic [COUNT_BITS-1:0] line_next;
    logic [COUNT_BITS-1:0] col_next;
    logic                  binary_next;

    // result register
    logic       out_valid_reg;
    count_out_t out_line_reg;
    count_out_t out_col_reg;

    logic                  proc_go;
    logic                  text_byte_seen;
    logic                  hit;
    logic [PATTERN_MAX-1:0] cmp_ok;
    logic [COUNT_BITS-1:0] start_col;
    logic [WIDE_W-1:0]     line_wide;
    logic [WIDE_W-1:0]     col_wide;

    assign proc_go       = in_valid_reg && (!out_valid_reg || match_out.ready);
    assign text_in.ready = !in_valid_reg || proc_go;

    assign match_out.valid         = out_valid_reg;
    assign match_out.line_number   = out_line_reg;
    assign match_out.column_number = out_col_reg;

    always_comb
    begin
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            pat_bytes[i] = pattern_word_reg[i / 8][(i % 8) * 8 +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                pattern_word_reg[w] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg  <= cfg_wr_data[LEN_W-1:0];
                REG_PATTERN_WORD_0: pattern_word_reg[0] <= cfg_wr_data;
                REG_PATTERN_WORD_1: pattern_word_reg[1] <= cfg_wr_data;
                REG_PATTERN_WORD_2: pattern_word_reg[2] <= cfg_wr_data;
                REG_PATTERN_WORD_3: pattern_word_reg[3] <= cfg_wr_data;
                default:            ;
            endcase
        end
    end

    // state seen by the byte, with file start clearing applied first
    always_comb
    begin
        if (in_start_reg)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                hist_cur[k] = '0;
            end
            bol_cur    = '0;
            line_cur   = COUNT_BITS'(1);
            col_cur    = '0;
            binary_cur = 1'b0;
        end
        else
        begin
            hist_cur   = hist_reg;
            bol_cur    = bol_reg;
            line_cur   = line_reg;
            col_cur    = col_reg;
            binary_cur = binary_reg;
        end
    end

    always_comb
    begin
        hist_next      = hist_cur;
        bol_next       = bol_cur;
        line_next      = line_cur;
        col_next       = col_cur;
        binary_next    = binary_cur;
        text_byte_seen = 1'b0;
        if (!binary_cur)
        begin
            if (in_byte_reg == CHAR_NUL)
            begin
                binary_next = 1'b1;
            end
            else if (in_byte_reg == CHAR_NEWLINE)
            begin
                if (line_cur != COUNT_MAX)
                begin
                    line_next = line_cur + COUNT_BITS'(1);
                end
                col_next = '0;
                bol_next = '0;
            end
            else
            begin
                text_byte_seen = 1'b1;
                if (col_cur != COUNT_MAX)
                begin
                    col_next = col_cur + COUNT_BITS'(1);
                end
                hist_next[0] = in_byte_reg;
                for (int k = 1; k < PATTERN_MAX; k++)
                begin
                    hist_next[k] = hist_cur[k-1];
                end
                if (bol_cur != BOL_W'(PATTERN_MAX))
                begin
                    bol_next = bol_cur + BOL_W'(1);
                end
            end
        end
    end

    // history byte j is compared with pattern byte length-1-j
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            cmp_ok[j] = (LEN_W'(j) >= pattern_length_reg) ||
                (hist_next[j] ==
                 pat_bytes[PAT_IDX_W'(pattern_length_reg - LEN_W'(1) - LEN_W'(j))]);
        end
    end

    assign hit = text_byte_seen &&
                 (pattern_length_reg != '0) &&
                 (pattern_length_reg <= LEN_W'(PATTERN_MAX)) &&
                 (LEN_W'(bol_next) >= pattern_length_reg) &&
                 (&cmp_ok);

    assign start_col = col_next - COUNT_BITS'(pattern_length_reg) + COUNT_BITS'(1);
    assign line_wide = WIDE_W'(line_next);
    assign col_wide  = WIDE_W'(start_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            in_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            in_byte_reg  <= text_in.text_byte;
            in_start_reg <= text_in.file_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                hist_reg[k] <= '0;
            end
            bol_reg    <= '0;
            line_reg   <= COUNT_BITS'(1);
            col_reg    <= '0;
            binary_reg <= 1'b0;
        end
        else if (proc_go)
        begin
            hist_reg   <= hist_next;
            bol_reg    <= bol_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            binary_reg <= binary_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_go)
        begin
            out_valid_reg <= hit;
        end
        else if (match_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && hit)
        begin
            out_line_reg <= line_wide[OUT_W-1:0];
            out_col_reg  <= col_wide[OUT_W-1:0];
        end
    end

    // checks
    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !text_in.ready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    a_bol_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bol_reg <= BOL_W'(PATTERN_MAX))
        else $error("line history count above depth");

    a_col_covers_history: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg >= COUNT_BITS'(bol_reg))
        else $error("column behind line history count");

    a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (COUNT_BITS > OUT_W) ||
                          ((out_line_reg != '0) && (out_col_reg != '0)))
        else $error("zero line or column in result");

endmodule

`default_nettype wire

FILE: tb/tb_literal_pattern_line_column_matcher.sv
// tb_literal_pattern_line_column_matcher: self-checking bench for the literal matcher
// drives text transactions, predicts line/column matches, checks each result in order
// depends on lplcm_pkg, lplcm_text_if, lplcm_match_if and the matcher top level
`timescale 1ns / 100ps

module tb_literal_pattern_line_column_matcher;
    import lplcm_pkg::*;

    typedef struct packed {
        byte_t text_byte;
        logic  file_start;
    } text_item_t;

    typedef struct packed {
        count_out_t line_no;
        count_out_t col_no;
    } match_pos_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam byte_t CHAR_A = 8'h61;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   tx_valid = 1'b0;
    byte_t                  tx_byte = '0;
    logic                   tx_first = 1'b0;
    logic                   rx_ready = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    lplcm_text_if  text_bus();
    lplcm_match_if match_bus();

    assign text_bus.valid      = tx_valid;
    assign text_bus.text_byte  = tx_byte;
    assign text_bus.file_start = tx_first;
    assign match_bus.ready     = rx_ready;

    literal_pattern_line_column_matcher u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_in     (text_bus),
        .match_out   (match_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor copy of configuration and per-file state
    logic [LEN_W-1:0]  pat_len;
    logic [WORD_W-1:0] pat_words [NUM_WORDS];
    byte_t             hist [PAT_BYTES];
    logic [LEN_W-1:0]  line_fill;
    count_out_t        line_cnt;
    count_out_t        col_cnt;
    logic              bin_seen;

    text_item_t pending_text [$];
    match_pos_t expected_matches [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int matches_seen = 0;
    int settings_run = 0;
    logic next_first = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic byte_t pattern_at(input int i);
        return pat_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    task automatic clear_file();
        for (int k = 0; k < PAT_BYTES; k++) hist[k] = '0;
        line_fill = '0;
        line_cnt = 24'd1;
        col_cnt = '0;
        bin_seen = 1'b0;
    endtask

    task automatic predict_text(input byte_t b, input logic fs);
        logic hit;
        int   n;
        hit = 1'b0;
        n = pat_len;
        if (fs) clear_file();
        if (!bin_seen) begin
            if (b == CHAR_NUL) begin
                bin_seen = 1'b1;
            end
            else if (b == CHAR_NEWLINE) begin
                if (line_cnt != '1) line_cnt++;
                col_cnt = '0;
                line_fill = '0;
            end
            else begin
                if (col_cnt != '1) col_cnt++;
                for (int k = PAT_BYTES - 1; k > 0; k--) hist[k] = hist[k - 1];
                hist[0] = b;
                if (line_fill < PAT_BYTES) line_fill++;
                if (n != 0 && n <= PAT_BYTES && line_fill >= n) begin
                    hit = 1'b1;
                    for (int i = 0; i < n; i++)
                        if (hist[n - 1 - i] != pattern_at(i)) hit = 1'b0;
                end
                if (hit)
                    expected_matches.push_back('{line_cnt,
                        count_out_t'(col_cnt - count_out_t'(n) + 24'd1)});
            end
        end
    endtask

    // text driver: one transaction per acceptance, random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tx_valid <= 1'b0;
            tx_byte  <= '0;
            tx_first <= 1'b0;
        end
        else begin
            if (text_bus.valid && text_bus.ready) begin
                predict_text(text_bus.text_byte, text_bus.file_start);
                bytes_sent++;
            end
            if (!text_bus.valid || text_bus.ready) begin
                if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    tx_valid <= 1'b1;
                    tx_byte  <= pending_text[0].text_byte;
                    tx_first <= pending_text[0].file_start;
                    void'(pending_text.pop_front());
                end
                else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // match monitor with random back-pressure
    always @(posedge clk or negedge rst_n) begin
        match_pos_t want;
        if (!rst_n) begin
            rx_ready <= 1'b0;
        end
        else begin
            if (match_bus.valid && match_bus.ready) begin
                matches_seen++;
                if (expected_matches.size() == 0) begin
                    report_mismatch($sformatf("unexpected match line %0d col %0d",
                        match_bus.line_number, match_bus.column_number));
                end
                else begin
                    want = expected_matches.pop_front();
                    if (match_bus.line_number !== want.line_no)
                        report_mismatch($sformatf("line_number %0d, want %0d",
                            match_bus.line_number, want.line_no));
                    if (match_bus.column_number !== want.col_no)
                        report_mismatch($sformatf("column_number %0d, want %0d",
                            match_bus.column_number, want.col_no));
                end
            end
            rx_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        if (idx == REG_PATTERN_LENGTH)
            pat_len = data[LEN_W-1:0];
        else if (idx <= REG_PATTERN_WORD_3)
            pat_words[idx - REG_PATTERN_WORD_0] = data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 10 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 10 : 0;
    endtask

    task automatic push_byte(input byte_t b);
        pending_text.push_back('{b, next_first});
        next_first = 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(byte_t'(s[i]));
    endtask

    task automatic drain();
        while (pending_text.size() != 0 || tx_valid || expected_matches.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        settings_run++;
    endtask

    function automatic byte_t filler();
        if ($urandom_range(99) < 80)
            return CHAR_A + byte_t'($urandom_range(2));
        return byte_t'($urandom_range(255));
    endfunction

    task automatic random_setting(input int p);
        logic [WORD_W-1:0] w;
        int                n;
        int                r;
        r = $urandom_range(99);
        if (p == 1) n = PAT_BYTES;
        else if (p == 2) n = 0;
        else if (p == 3) n = 63;
        else if (r < 8) n = 0;
        else if (r < 16) n = $urandom_range(63, 33);
        else if (r < 26) n = PAT_BYTES;
        else n = $urandom_range(6, 1);
        for (int wi = 0; wi < NUM_WORDS; wi++) begin
            for (int bi = 0; bi < 8; bi++) begin
                r = $urandom_range(99);
                if (wi * 8 + bi >= n) w[bi * 8 +: 8] = byte_t'($urandom_range(255));
                else if (r < 88) w[bi * 8 +: 8] = CHAR_A + byte_t'($urandom_range(2));
                else if (r < 92) w[bi * 8 +: 8] = CHAR_NEWLINE;
                else w[bi * 8 +: 8] = byte_t'($urandom_range(255, 1));
            end
            write_reg(REG_PATTERN_WORD_0 + wi[CFG_INDEX_W-1:0], w);
        end
        if ($urandom_range(3) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(7, 5)), {$urandom, $urandom});
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(n));
    endtask

    task automatic random_text(input int count);
        int n;
        int r;
        int k;
        int added;
        added = 0;
        n = (pat_len <= PAT_BYTES) ? pat_len : 0;
        while (added < count) begin
            r = $urandom_range(99);
            if (r < 50 && n != 0) begin
                for (int i = 0; i < n; i++) push_byte(pattern_at(i));
                added += n;
            end
            else if (r < 60 && n > 1) begin
                k = $urandom_range(n - 1, 1);
                for (int i = 0; i < k; i++) push_byte(pattern_at(i));
                push_byte(filler());
                added += k + 1;
            end
            else if (r < 85) begin
                k = $urandom_range(3, 1);
                for (int i = 0; i < k; i++) push_byte(filler());
                added += k;
            end
            else if (r < 92) begin
                push_byte(CHAR_NEWLINE);
                added++;
            end
            else if (r < 94) begin
                push_byte(CHAR_NUL);
                added++;
            end
            else if (r < 97) begin
                next_first = 1'b1;
            end
            else begin
                push_byte(byte_t'($urandom_range(255)));
                added++;
            end
        end
    endtask

    initial begin
        int p;
        int random_items;
        pat_len = '0;
        for (int i = 0; i < NUM_WORDS; i++) pat_words[i] = '0;
        clear_file();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: overlap, newline break, binary file, restart, 0xff byte
        set_idle(IDLE_NONE);
        write_reg(REG_PATTERN_WORD_0, 64'h0000_0000_0061_6261);
        write_reg(REG_PATTERN_WORD_1, '0);
        write_reg(REG_PATTERN_WORD_2, '1);
        write_reg(REG_PATTERN_WORD_3, '0);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        next_first = 1'b1;
        push_text("ababa\nab\na");
        push_byte(8'hFF);
        push_byte(CHAR_NUL);
        push_text("aba");
        next_first = 1'b1;
        push_text("aba");
        drain();

        // newline inside the pattern never matches
        write_reg(REG_PATTERN_WORD_0, {48'h0, CHAR_NEWLINE, CHAR_A});
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        next_first = 1'b1;
        push_text("a\na");
        drain();

        // empty pattern
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        push_text("aa");
        drain();

        p = 0;
        random_items = 0;
        while (random_items < 600 || p < 12) begin
            set_idle(idle_mode_t'(p % 4));
            random_setting(p);
            next_first = 1'b1;
            random_text((pat_len == PAT_BYTES) ? 150 : 45);
            random_items += pending_text.size();
            drain();
            p++;
        end

        $display("sent %0d text bytes under %0d pattern settings, %0d matches checked",
            bytes_sent, settings_run, matches_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
